/* rtl/tcphc_pkg.sv */
// Package with shared types and constants of the TCP header delta compressor.
`default_nettype none

package tcphc_pkg;

  localparam int unsigned FrameBytes = 15;
  localparam int unsigned LenW       = $clog2(FrameBytes + 1);
  localparam int unsigned IdxW       = $clog2(FrameBytes);

  localparam logic [15:0] ModeBase   = 16'hC000;
  localparam logic [15:0] ModeFin    = 16'h0008;
  localparam logic [7:0]  PrefixByte = 8'h01;

  localparam logic [1:0] CodeSame = 2'd0;
  localparam logic [1:0] CodeLow  = 2'd1;
  localparam logic [1:0] CodeMid  = 2'd2;
  localparam logic [1:0] CodeFull = 2'd3;

  typedef struct packed {
    logic [FrameBytes-1:0][7:0] bytes;
    logic [LenW-1:0]            len;
  } frame_t;

endpackage

`default_nettype wire

/* rtl/tcphc_encode.sv */
// Encoder: codes one header against the context and lays out its byte frame.
`default_nettype none

module tcphc_encode (
  input  wire logic               established_i,
  input  wire logic [31:0]        seq_number_i,
  input  wire logic [31:0]        ack_number_i,
  input  wire logic [15:0]        window_size_i,
  input  wire logic               fin_flag_i,
  input  wire logic [15:0]        checksum_value_i,
  input  wire logic [7:0]         context_id_i,
  input  wire logic [31:0]        prev_seq_i,
  input  wire logic [31:0]        prev_ack_i,
  input  wire logic [15:0]        prev_window_i,
  output tcphc_pkg::frame_t       frame_o
);
  import tcphc_pkg::*;

  logic [1:0]      seq_code, ack_code, win_code;
  logic [2:0]      seq_n, ack_n;
  logic [1:0]      win_n;
  logic [15:0]     mode;
  logic [LenW-1:0] off_a, off_w, off_c, off_e;
  logic [3:0][7:0] seq_b, ack_b;
  logic [LenW-1:0] k4, rel;

  function automatic logic [1:0] code32(input logic [31:0] now, input logic [31:0] prior);
    logic [1:0] c;
    priority if (now == prior) c = CodeSame;
    else if (now[31:8] == prior[31:8]) c = CodeLow;
    else if (now[31:16] == prior[31:16]) c = CodeMid;
    else c = CodeFull;
    return c;
  endfunction

  function automatic logic [2:0] bytes32(input logic [1:0] c);
    logic [2:0] n;
    unique case (c)
      CodeSame: n = 3'd0;
      CodeLow:  n = 3'd1;
      CodeMid:  n = 3'd2;
      default:  n = 3'd4;
    endcase
    return n;
  endfunction

  always_comb begin
    seq_code = code32(seq_number_i, prev_seq_i);
    ack_code = code32(ack_number_i, prev_ack_i);
    priority if (window_size_i == prev_window_i) win_code = CodeSame;
    else if (window_size_i[15:8] == prev_window_i[15:8]) win_code = CodeLow;
    else if (window_size_i[7:0] == prev_window_i[7:0]) win_code = CodeMid;
    else win_code = CodeFull;
    seq_n = bytes32(seq_code);
    ack_n = bytes32(ack_code);
    win_n = (win_code == CodeSame) ? 2'd0 : (win_code == CodeFull) ? 2'd2 : 2'd1;
    mode  = ModeBase | {4'd0, seq_code, ack_code, win_code, 6'd0}
          | (fin_flag_i ? ModeFin : 16'd0);
    off_a = LenW'(4'd3) + LenW'(seq_n);
    off_w = off_a + LenW'(ack_n);
    off_c = off_w + LenW'(win_n);
    off_e = off_c + LenW'(2'd2);
    seq_b = seq_number_i;
    ack_b = ack_number_i;
  end

  always_comb begin
    frame_o = '0;
    k4      = '0;
    rel     = '0;
    if (!established_i) begin
      frame_o.bytes[0] = PrefixByte;
      frame_o.bytes[1] = context_id_i;
      frame_o.len      = LenW'(2);
    end else begin
      frame_o.len = off_e;
      for (int k = 0; k < FrameBytes; k++) begin
        k4 = LenW'(k);
        priority if (k4 == LenW'(0)) begin
          frame_o.bytes[k] = mode[7:0];
        end else if (k4 == LenW'(1)) begin
          frame_o.bytes[k] = mode[15:8];
        end else if (k4 == LenW'(2)) begin
          frame_o.bytes[k] = context_id_i;
        end else if (k4 < off_a) begin
          rel = k4 - LenW'(3);
          frame_o.bytes[k] = seq_b[rel[1:0]];
        end else if (k4 < off_w) begin
          rel = k4 - off_a;
          frame_o.bytes[k] = ack_b[rel[1:0]];
        end else if (k4 < off_c) begin
          rel = k4 - off_w;
          frame_o.bytes[k] = (win_code == CodeMid || rel[0]) ? window_size_i[15:8]
                                                             : window_size_i[7:0];
        end else if (k4 < off_e) begin
          rel = k4 - off_c;
          frame_o.bytes[k] = rel[0] ? checksum_value_i[15:8] : checksum_value_i[7:0];
        end else begin
          frame_o.bytes[k] = 8'd0;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/tcphc_serializer.sv */
// Serializer: frame holding register and byte output stage.
`default_nettype none

module tcphc_serializer (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire tcphc_pkg::frame_t frame_i,
  output logic                   ready_o,
  output logic                   valid_o,
  input  wire logic              take_i,
  output logic [7:0]             byte_o,
  output logic                   last_o
);
  import tcphc_pkg::*;

  frame_t          pend_q, out_q;
  logic            pend_valid_q, out_valid_q;
  logic [LenW-1:0] idx_q;
  logic            fire, done, out_free, move;

  assign fire     = out_valid_q & take_i;
  assign last_o   = idx_q == (out_q.len - LenW'(1));
  assign done     = fire & last_o;
  assign out_free = ~out_valid_q | done;
  assign move     = pend_valid_q & out_free;
  assign ready_o  = ~pend_valid_q | move;
  assign valid_o  = out_valid_q;
  assign byte_o   = out_q.bytes[idx_q[IdxW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      idx_q        <= '0;
    end else begin
      if (load_i) begin
        pend_valid_q <= 1'b1;
      end else if (move) begin
        pend_valid_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
        idx_q       <= '0;
      end else if (done) begin
        out_valid_q <= 1'b0;
      end else if (fire) begin
        idx_q <= idx_q + LenW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pend_q <= frame_i;
    end
    if (move) begin
      out_q <= pend_q;
    end
  end

endmodule

`default_nettype wire

/* rtl/tcp_header_delta_compressor_core.sv */
// Top level of the TCP header delta compressor: handshakes, context and config.
//
// Usage:
//   s_axis carries one TCP header per word; tuser is the established flag.
//   m_axis carries the compressed header, one byte per word, tlast on the
//   final byte. cfg writes the context id, always ready; write it while idle.
//   A header accepted on s_axis is coded against the context at once and
//   written into a frame register (pend_q); it moves into the output
//   register (out_q) when the output stage is free, and its frame of 2 to
//   15 bytes leaves the single byte-wide port one byte per cycle unless stalled.
//   One further header waits in the frame register while a frame drains,
//   so input is accepted again as soon as that register empties.
//   When the receiver stalls, the current byte holds and input stops once
//   the frame register is full.
//   Reset clears the context (sequence, acknowledgment, window), the context
//   id and all valid flags.
`default_nettype none

module tcp_header_delta_compressor_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [7:0]   cfg_data_i,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // seq_number[31:0], ack_number[63:32], window_size[79:64], fin_flag[80],
  // checksum_value[96:81], zero pad[103:97]
  input  wire logic [103:0] s_axis_tdata_i,
  // established[0]
  input  wire logic         s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // out_byte[7:0]
  output logic [7:0]        m_axis_tdata_o,
  output logic              m_axis_tlast_o
);
  import tcphc_pkg::*;

  logic [7:0]  context_id_q;
  logic [31:0] prev_seq_q, prev_ack_q;
  logic [15:0] prev_window_q;
  logic        s_fire;
  frame_t      frame;

  assign cfg_ready_o = 1'b1;
  assign s_fire      = s_axis_tvalid_i & s_axis_tready_o;

  tcphc_encode u_encode (
    .established_i    (s_axis_tuser_i),
    .seq_number_i     (s_axis_tdata_i[31:0]),
    .ack_number_i     (s_axis_tdata_i[63:32]),
    .window_size_i    (s_axis_tdata_i[79:64]),
    .fin_flag_i       (s_axis_tdata_i[80]),
    .checksum_value_i (s_axis_tdata_i[96:81]),
    .context_id_i     (context_id_q),
    .prev_seq_i       (prev_seq_q),
    .prev_ack_i       (prev_ack_q),
    .prev_window_i    (prev_window_q),
    .frame_o          (frame)
  );

  tcphc_serializer u_serializer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (s_fire),
    .frame_i (frame),
    .ready_o (s_axis_tready_o),
    .valid_o (m_axis_tvalid_o),
    .take_i  (m_axis_tready_i),
    .byte_o  (m_axis_tdata_o),
    .last_o  (m_axis_tlast_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      context_id_q  <= '0;
      prev_seq_q    <= '0;
      prev_ack_q    <= '0;
      prev_window_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        context_id_q <= cfg_data_i;
      end
      if (s_fire) begin
        prev_seq_q    <= s_axis_tdata_i[31:0];
        prev_ack_q    <= s_axis_tdata_i[63:32];
        prev_window_q <= s_axis_tdata_i[79:64];
      end
    end
  end

endmodule

`default_nettype wire
